[rtl/core/mhfb_pkg.sv]
package mhfb_pkg;

    // Register map of the configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_MCAST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ADDR = 2'd2;
    localparam int unsigned CFG_DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [7:0] MAX_ADDR_RESET = 8'd64;

    // CRC engine constants
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam int unsigned MAC_W = 48;
    localparam int unsigned BIT_CNT_W = 6;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 6'(MAC_W - 1);
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [MAC_W-1:0] mac_address;
        logic clear_first;
    } t_in_item;

    typedef struct packed {
        logic [31:0] hash_high;
        logic [31:0] hash_low;
        logic overflowed;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_FIN
    } t_state;

endpackage

[rtl/core/multicast_hash_filter_builder.sv]
// A new address is taken only while busy is low. Busy stays high through the CRC pass,
// which shifts one address bit per cycle through the single CRC bit-step unit, and through
// the finish step, which registers the result and its strobe.
// Reset (synchronous, active low) clears the sequencer, the hash table and the address count,
// and loads the default polynomial, all-multicast off and an address limit of 64.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multicast_hash_filter_builder
    import mhfb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                r_state, n_state;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [MAC_W-1:0]      r_mac, n_mac;
    logic                  r_clr, n_clr;
    logic [31:0]           r_crc, n_crc;
    logic [31:0]           r_tbl_hi, n_tbl_hi;
    logic [31:0]           r_tbl_lo, n_tbl_lo;
    logic [7:0]            r_count, n_count;
    logic                  r_valid, n_valid;
    t_out_item             r_result, n_result;

    logic [31:0]           r_poly;
    logic                  r_all_mcast;
    logic [7:0]            r_max_addr;

    // Finish-step helpers
    logic [4:0]            hash_idx;
    logic [31:0]           hash_mask;
    logic [31:0]           base_hi, base_lo;
    logic [7:0]            base_count;
    logic                  over;

    // Configuration registers: plain writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= POLY_RESET;
            r_all_mcast <= 1'b0;
            r_max_addr  <= MAX_ADDR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CRC_POLY:  r_poly      <= i_cfg_data;
                REG_ALL_MCAST: r_all_mcast <= i_cfg_data[0];
                REG_MAX_ADDR:  r_max_addr  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_tbl_hi  <= '0;
            r_tbl_lo  <= '0;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_tbl_hi  <= n_tbl_hi;
            r_tbl_lo  <= n_tbl_lo;
            r_count   <= n_count;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac    <= n_mac;
        r_clr    <= n_clr;
        r_crc    <= n_crc;
        r_result <= n_result;
    end

    // Bit index is CRC bits 5..1 reversed; bit 0 picks the word
    assign hash_idx   = {r_crc[1], r_crc[2], r_crc[3], r_crc[4], r_crc[5]};
    assign hash_mask  = 32'd1 << hash_idx;
    assign base_hi    = r_clr ? '0 : r_tbl_hi;
    assign base_lo    = r_clr ? '0 : r_tbl_lo;
    assign base_count = r_clr ? '0 : r_count;

    // Next state and outputs
    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_mac     = r_mac;
        n_clr     = r_clr;
        n_crc     = r_crc;
        n_tbl_hi  = r_tbl_hi;
        n_tbl_lo  = r_tbl_lo;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_result  = r_result;
        over      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mac     = i_item.mac_address;
                    n_clr     = i_item.clear_first;
                    n_crc     = CRC_INIT;
                    n_bit_cnt = '0;
                    n_state   = S_CRC;
                end
            end
            S_CRC: begin
                // one CRC bit step, LSB of the address first
                n_crc = {r_crc[30:0], 1'b0} ^ ((r_crc[31] ^ r_mac[0]) ? r_poly : '0);
                n_mac = r_mac >> 1;
                if (r_bit_cnt == LAST_BIT) begin
                    n_state = S_FIN;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                end
            end
            S_FIN: begin
                n_tbl_hi = r_crc[0] ? (base_hi | hash_mask) : base_hi;
                n_tbl_lo = r_crc[0] ? base_lo : (base_lo | hash_mask);
                n_count  = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 1'b1;
                over     = r_all_mcast || (n_count > r_max_addr);
                n_result.hash_high  = over ? ALL_ONES : n_tbl_hi;
                n_result.hash_low   = over ? ALL_ONES : n_tbl_lo;
                n_result.overflowed = over;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Checks
    a_valid_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_start_begins_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_CRC && r_bit_cnt == '0))
        else $error("accepted item did not start the CRC pass");

    a_fin_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_valid && !busy))
        else $error("finish step did not deliver a result");

    a_over_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.overflowed) |->
            (o_result.hash_high == ALL_ONES && o_result.hash_low == ALL_ONES))
        else $error("overflowed result without forced table");

endmodule

[test/multicast_hash_filter_builder_tb.sv]
`timescale 1ns / 100ps

module multicast_hash_filter_builder_tb;
    import mhfb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned NUM_PHASES = 9;

    typedef enum logic [1:0] {
        CMD_ITEM,
        CMD_CFG,
        CMD_DRAIN
    } t_cmd_kind;

    typedef struct {
        t_cmd_kind kind;
        t_in_item item;
        int unsigned gap;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_valid;
    t_out_item o_result;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_CRC_POLY;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // stimulus commands and predicted filter tables
    t_cmd pending[$];
    t_out_item expected_tables[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    // predictor copy of configuration and hash state
    logic [31:0] cfg_poly = POLY_RESET;
    logic cfg_all_mcast = 1'b0;
    logic [7:0] cfg_max_addr = MAX_ADDR_RESET;
    logic [31:0] group_hi = '0;
    logic [31:0] group_lo = '0;
    logic [7:0] group_count = '0;

    multicast_hash_filter_builder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Insert one address into the predicted table, return the effective table
    function automatic t_out_item hash_insert(t_in_item it);
        logic [31:0] crc;
        logic [4:0] bitpos;
        logic top;
        t_out_item res;
        crc = CRC_INIT;
        for (int k = 0; k < MAC_W; k++) begin
            top = crc[31];
            crc = crc << 1;
            if (top ^ it.mac_address[k])
                crc = crc ^ cfg_poly;
        end
        if (it.clear_first) begin
            group_hi = '0;
            group_lo = '0;
            group_count = '0;
        end
        // hash field crc[5:1], bit-reversed
        bitpos = {crc[1], crc[2], crc[3], crc[4], crc[5]};
        if (crc[0])
            group_hi[bitpos] = 1'b1;
        else
            group_lo[bitpos] = 1'b1;
        if (group_count != COUNT_MAX)
            group_count = group_count + 8'd1;
        res.overflowed = cfg_all_mcast || (group_count > cfg_max_addr);
        res.hash_high = res.overflowed ? ALL_ONES : group_hi;
        res.hash_low = res.overflowed ? ALL_ONES : group_lo;
        return res;
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic push_item(logic [MAC_W-1:0] mac, logic clr, int unsigned gap);
        t_cmd c;
        c.kind = CMD_ITEM;
        c.item.mac_address = mac;
        c.item.clear_first = clr;
        c.gap = gap;
        c.idx = REG_CRC_POLY;
        c.data = '0;
        pending.push_back(c);
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_cmd c;
        c.kind = CMD_CFG;
        c.item = '0;
        c.gap = 0;
        c.idx = idx;
        c.data = data;
        pending.push_back(c);
    endtask

    task automatic push_drain();
        t_cmd c;
        c.kind = CMD_DRAIN;
        c.item = '0;
        c.gap = 0;
        c.idx = REG_CRC_POLY;
        c.data = '0;
        pending.push_back(c);
    endtask

    // Random address: fully random, IPv4 or IPv6 style group, or any group address
    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return r[47:0];
            1: return {r[15:0], 1'b0, r[22:16], 24'h5E_00_01};
            2: return {r[31:0], 16'h33_33};
            default: return {r[47:1], 1'b1};
        endcase
    endfunction

    // Driver: sends items and register writes from the pending queue
    t_cmd head_cmd;
    logic taken;
    logic next_start;
    logic next_we;
    int unsigned in_flight;
    int unsigned quiet_cycles;
    int unsigned gap_left;
    bit gap_loaded;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
            i_cfg_we <= 1'b0;
            i_cfg_idx <= REG_CRC_POLY;
            i_cfg_data <= '0;
            in_flight = 0;
            quiet_cycles = 0;
            gap_left = 0;
            gap_loaded = 1'b0;
        end else begin
            taken = start && !busy;
            if (taken)
                in_flight++;
            if (o_valid)
                in_flight--;
            if (!busy && !taken && in_flight == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            next_start = start && !taken;
            next_we = 1'b0;
            if (!next_start && pending.size() != 0) begin
                head_cmd = pending[0];
                case (head_cmd.kind)
                    CMD_ITEM: begin
                        if (!gap_loaded) begin
                            gap_left = head_cmd.gap;
                            gap_loaded = 1'b1;
                        end
                        if (gap_left == 0) begin
                            next_start = 1'b1;
                            i_item <= head_cmd.item;
                            void'(pending.pop_front());
                            gap_loaded = 1'b0;
                        end else if (!busy) begin
                            gap_left--;
                        end
                    end
                    CMD_CFG: begin
                        // registers change only once the block has gone quiet
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            next_we = 1'b1;
                            i_cfg_idx <= head_cmd.idx;
                            i_cfg_data <= head_cmd.data;
                            void'(pending.pop_front());
                        end
                    end
                    default: begin
                        if (in_flight == 0)
                            void'(pending.pop_front());
                    end
                endcase
            end
            start <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // Monitor: checks results, tracks register writes, predicts each transfer
    t_out_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_poly = POLY_RESET;
            cfg_all_mcast = 1'b0;
            cfg_max_addr = MAX_ADDR_RESET;
            group_hi = '0;
            group_lo = '0;
            group_count = '0;
        end else begin
            if (o_valid) begin
                results_seen++;
                if (expected_tables.size() == 0) begin
                    flag_error($sformatf("result %0d with nothing expected: %h",
                                         results_seen, o_result));
                end else begin
                    want = expected_tables.pop_front();
                    if (o_result.hash_high !== want.hash_high)
                        flag_error($sformatf("result %0d hash_high expected %h got %h",
                                             results_seen, want.hash_high, o_result.hash_high));
                    if (o_result.hash_low !== want.hash_low)
                        flag_error($sformatf("result %0d hash_low expected %h got %h",
                                             results_seen, want.hash_low, o_result.hash_low));
                    if (o_result.overflowed !== want.overflowed)
                        flag_error($sformatf("result %0d overflowed expected %b got %b",
                                             results_seen, want.overflowed,
                                             o_result.overflowed));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CRC_POLY: cfg_poly = i_cfg_data;
                    REG_ALL_MCAST: cfg_all_mcast = i_cfg_data[0];
                    REG_MAX_ADDR: cfg_max_addr = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_tables.push_back(hash_insert(i_item));
        end
    end

    // Watchdog: cycles without any transfer in or out
    int unsigned stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus and end of test
    int unsigned n_items;
    int unsigned gap;
    bit idle_mode;
    bit clr;
    logic [31:0] poly;
    logic am;
    logic [7:0] max_addr;

    initial begin
        // directed: reset defaults, corner addresses
        push_item(48'h0, 1'b1, 0);
        push_item(48'hFFFF_FFFF_FFFF, 1'b0, 0);
        push_item(48'h01_00_00_5E_00_01, 1'b0, 0);
        push_item(48'h01_00_00_00_33_33, 1'b0, 0);
        push_item(48'h54_44_33_22_11_00, 1'b0, 0);   // unicast address, hashed anyway
        push_item(48'h5555_5555_5555, 1'b0, 0);
        push_item(48'hAAAA_AAAA_AAAA, 1'b0, 0);
        push_item(48'h8000_0000_0000, 1'b0, 0);
        push_item(48'h0000_0000_0001, 1'b0, 0);
        push_item(random_mac(), 1'b1, 0);
        // limit of zero: first insert already overflows
        push_cfg(REG_MAX_ADDR, $urandom & 32'hFFFF_FF00);
        push_item(random_mac(), 1'b1, 0);
        push_item(random_mac(), 1'b0, 0);
        // all-multicast forces ones, stored table keeps accumulating
        push_cfg(REG_ALL_MCAST, 32'hFFFF_FFFF);
        push_cfg(REG_MAX_ADDR, ($urandom & 32'hFFFF_FF00) | 32'd64);
        push_item(random_mac(), 1'b0, 0);
        push_item(random_mac(), 1'b0, 0);
        push_cfg(REG_ALL_MCAST, 32'hFFFF_FFFE);
        push_item(random_mac(), 1'b0, 0);
        // unmapped index must be ignored
        push_cfg(REG_UNUSED, $urandom);
        push_cfg(REG_CRC_POLY, 32'h0);
        push_item(48'hFFFF_FFFF_FFFF, 1'b1, 0);
        push_item(random_mac(), 1'b0, 0);
        push_cfg(REG_CRC_POLY, 32'hFFFF_FFFF);
        push_item(48'h0, 1'b0, 0);
        push_item(random_mac(), 1'b0, 0);
        push_cfg(REG_CRC_POLY, POLY_RESET);
        push_cfg(REG_MAX_ADDR, 32'd255);
        push_item(random_mac(), 1'b1, 0);

        // random phases, each with its own register setting
        idle_mode = 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: poly = POLY_RESET;
                1: poly = 32'hFFFF_FFFF;
                2: poly = 32'h0;
                default: poly = $urandom_range(0, 1) ? POLY_RESET : $urandom;
            endcase
            am = (p == 3) ? 1'b1 : ((p == 4 || p == 5) ? 1'b0 : ($urandom_range(0, 4) == 0));
            case (p)
                4: max_addr = 8'd254;   // count saturates at 255 and then stays over
                5: max_addr = 8'd255;   // saturated count never exceeds the limit
                6: max_addr = 8'd0;
                default: max_addr = $urandom_range(0, 1) ? MAX_ADDR_RESET
                                                         : 8'($urandom_range(0, 255));
            endcase
            push_cfg(REG_CRC_POLY, poly);
            push_cfg(REG_ALL_MCAST, ($urandom & 32'hFFFF_FFFE) | 32'(am));
            push_cfg(REG_MAX_ADDR, ($urandom & 32'hFFFF_FF00) | 32'(max_addr));
            if ($urandom_range(0, 2) == 0)
                push_cfg(REG_UNUSED, $urandom);
            n_items = (p == 4 || p == 5) ? 280 : 50;
            for (int i = 0; i < n_items; i++) begin
                if (p == 4 || p == 5)
                    clr = (i == 0);
                else
                    clr = (i == 0) || ($urandom_range(0, 11) == 0);
                if ($urandom_range(0, 29) == 0)
                    idle_mode = !idle_mode;
                gap = 0;
                // no idling in the last phase
                if (p != NUM_PHASES - 1 && idle_mode && $urandom_range(0, 1) == 1)
                    gap = $urandom_range(1, 12);
                push_item(random_mac(), clr, gap);
                if ($urandom_range(0, 39) == 0)
                    push_drain();
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (pending.size() != 0 || start || in_flight != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_tables.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[multicast_hash_filter_builder.f]
rtl/core/mhfb_pkg.sv
rtl/core/multicast_hash_filter_builder.sv
test/multicast_hash_filter_builder_tb.sv
